// ===== rtl/core/blob_request_record_validator_unit_assert.svh =====
// Assertion macros for the request record validator.
// Used by the top level; no other dependencies.
`ifndef BLOB_REQUEST_RECORD_VALIDATOR_UNIT_ASSERT_SVH
`define BLOB_REQUEST_RECORD_VALIDATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define BRRV_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("label");
`define BRRV_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("label");
`else
`define BRRV_ASSERT_IMP(label, clk, rst, a, c)
`define BRRV_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

// ===== rtl/core/brrv_pkg.sv =====
// Package of the request record validator: payload types, codes, limits.
// No dependencies.
package brrv_pkg;
  localparam int MaxLineLen = 371;
  localparam int MaxDigestLen = 137;
  localparam int MaxTransportTail = 128;
  localparam int DigestMin = 34;
  localparam int QDepth = 4;
  localparam logic [63:0] CountLimit = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] SecondsLimit = 32'h7FFF_FFFF;

  typedef enum logic [2:0] {
    ST_LINE_OK = 3'd0, ST_LINE_BAD = 3'd1, ST_STREAM_OK = 3'd2,
    ST_STREAM_BAD = 3'd3, ST_EMPTY = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    EF_NONE = 4'd0, EF_TIME = 4'd1, EF_TRANSPORT = 4'd2, EF_VERB = 4'd3,
    EF_DIGEST = 4'd4, EF_CHAT = 4'd5, EF_COUNT = 4'd6, EF_DURATION = 4'd7,
    EF_LENGTH = 4'd8
  } err_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  error_field;
    logic [31:0] line_number;
  } out_item_t;
endpackage

// ===== rtl/core/brrv_front.sv =====
// Front part: parses one byte per cycle while take is high and emits a line or stream verdict.
// Depends on brrv_pkg.
module brrv_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  brrv_pkg::in_item_t  item,
  output logic                res_valid,
  output brrv_pkg::out_item_t res
);
  typedef enum logic [3:0] {
    PH_TS, PH_FRAC, PH_ZONE, PH_TR_HEAD, PH_TR_TAIL, PH_VERB, PH_DIG_ALGO,
    PH_DIG_HASH, PH_CHAT, PH_COUNT, PH_SEC, PH_NS, PH_DONE
  } phase_t;

  phase_t      parse_phase, parse_phase_next;
  logic [7:0]  field_char_count, field_char_count_next;
  logic [8:0]  line_char_count, line_char_count_next;
  logic [2:0]  verb_code, verb_code_next;
  logic [3:0]  chat_pattern, chat_pattern_next;
  logic        digest_empty, digest_empty_next;
  logic [63:0] count_accum, count_accum_next;
  logic [31:0] seconds_accum, seconds_accum_next;
  logic [3:0]  line_failed, line_failed_next;
  logic        stream_bad, seen_input;
  logic [31:0] line_counter;
  logic [3:0]  perr;

  function automatic logic is_dig(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction
  function automatic logic is_low(input logic [7:0] c);
    return c >= 8'h61 && c <= 8'h7a;
  endfunction
  function automatic logic is_gr(input logic [7:0] c);
    return c >= 8'h21 && c <= 8'h7e;
  endfunction
  function automatic logic ts_ok(input logic [4:0] n, input logic [7:0] c);
    case (n)
      5'd0: return c >= "2" && c <= "5";
      5'd4, 5'd7: return c == "-";
      5'd5: return c == "0" || c == "1";
      5'd8: return c >= "0" && c <= "3";
      5'd10: return c == "T";
      5'd11: return c >= "0" && c <= "2";
      5'd13, 5'd16: return c == ":";
      5'd14, 5'd17: return c >= "0" && c <= "5";
      5'd19: return c == ".";
      5'd1, 5'd2, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15, 5'd18: return is_dig(c);
      default: return 1'b0;
    endcase
  endfunction
  function automatic logic [7:0] verb_ch(input logic [2:0] v, input logic [1:0] i);
    logic [31:0] t;
    case (v)
      3'd0: t = "get ";
      3'd1: t = "put ";
      3'd2: t = "give";
      3'd3: t = "take";
      3'd4: t = "eat ";
      3'd5: t = "wrap";
      default: t = "roll";
    endcase
    return t[8'(31 - 8 * i) -: 8];
  endfunction
  function automatic logic [3:0] chat_nx(input logic [3:0] s, input logic [1:0] y);
    case ({s, y})
      {4'd0, 2'd0}: return 4'd1;
      {4'd0, 2'd1}: return 4'd3;
      {4'd1, 2'd1}: return 4'd2;
      {4'd3, 2'd2}: return 4'd4;
      {4'd4, 2'd3}: return 4'd5;
      {4'd5, 2'd0}: return 4'd8;
      {4'd5, 2'd1}: return 4'd6;
      {4'd6, 2'd2}: return 4'd7;
      {4'd7, 2'd3}: return 4'd10;
      {4'd8, 2'd1}: return 4'd9;
      {4'd10, 2'd0}: return 4'd13;
      {4'd10, 2'd1}: return 4'd11;
      {4'd11, 2'd2}: return 4'd12;
      {4'd13, 2'd1}: return 4'd14;
      default: return 4'd15;
    endcase
  endfunction

  logic [7:0]  c;
  logic [3:0]  d;
  logic        chat_ok, is_no, vwr;
  logic [67:0] cmul;
  logic [35:0] smul;

  always_comb begin
    c = item.data_byte;
    d = c[3:0];
    parse_phase_next = parse_phase;
    field_char_count_next = field_char_count;
    verb_code_next = verb_code;
    chat_pattern_next = chat_pattern;
    digest_empty_next = digest_empty;
    count_accum_next = count_accum;
    seconds_accum_next = seconds_accum;
    perr = brrv_pkg::EF_NONE;
    is_no = chat_pattern == 4'd2 || chat_pattern == 4'd9 || chat_pattern == 4'd14;
    vwr = verb_code == 3'd5 || verb_code == 3'd6;
    case (chat_pattern)
      4'd2: chat_ok = 1'b1;
      4'd4: chat_ok = verb_code == 3'd0 || verb_code == 3'd4 || vwr;
      4'd7, 4'd9: chat_ok = verb_code == 3'd1 || verb_code == 3'd2 || verb_code == 3'd3;
      4'd12, 4'd14: chat_ok = verb_code == 3'd2 || verb_code == 3'd3;
      default: chat_ok = 1'b0;
    endcase
    if (chat_ok && vwr && (digest_empty != is_no)) chat_ok = 1'b0;
    cmul = ({4'd0, count_accum} << 3) + ({4'd0, count_accum} << 1) + {64'd0, d};
    smul = ({4'd0, seconds_accum} << 3) + ({4'd0, seconds_accum} << 1) + {32'd0, d};
    case (parse_phase)
      PH_TS: begin
        if (field_char_count >= 8'd20 || !ts_ok(field_char_count[4:0], c)) begin
          perr = brrv_pkg::EF_TIME;
        end else if (field_char_count == 8'd19) begin
          parse_phase_next = PH_FRAC; field_char_count_next = 8'd0;
        end else field_char_count_next = field_char_count + 8'd1;
      end
      PH_FRAC: begin
        if (is_dig(c) && field_char_count < 8'd9) field_char_count_next = field_char_count + 8'd1;
        else if (field_char_count >= 8'd1 && (c == "+" || c == "-")) begin
          parse_phase_next = PH_ZONE; field_char_count_next = 8'd0;
        end else perr = brrv_pkg::EF_TIME;
      end
      PH_ZONE: begin
        if (field_char_count >= 8'd6) perr = brrv_pkg::EF_TIME;
        else if (field_char_count == 8'd2 ? c != ":" :
                 field_char_count == 8'd5 ? c != 8'h09 : !is_dig(c)) perr = brrv_pkg::EF_TIME;
        else if (field_char_count == 8'd5) begin
          parse_phase_next = PH_TR_HEAD; field_char_count_next = 8'd0;
        end else field_char_count_next = field_char_count + 8'd1;
      end
      PH_TR_HEAD: begin
        if (field_char_count == 8'd0) begin
          if (!is_low(c)) perr = brrv_pkg::EF_TRANSPORT;
          else field_char_count_next = 8'd1;
        end else if (c == "~") begin
          parse_phase_next = PH_TR_TAIL; field_char_count_next = 8'd0;
        end else if ((is_low(c) || is_dig(c)) && field_char_count < 8'd8)
          field_char_count_next = field_char_count + 8'd1;
        else perr = brrv_pkg::EF_TRANSPORT;
      end
      PH_TR_TAIL: begin
        if (c == 8'h09 && field_char_count >= 8'd1) begin
          parse_phase_next = PH_VERB; field_char_count_next = 8'd0;
        end else if (is_gr(c) && 32'(field_char_count) < brrv_pkg::MaxTransportTail)
          field_char_count_next = field_char_count + 8'd1;
        else perr = brrv_pkg::EF_TRANSPORT;
      end
      PH_VERB: begin
        if (field_char_count == 8'd0) begin
          field_char_count_next = 8'd1;
          case (c)
            "g": verb_code_next = 3'd0;
            "p": verb_code_next = 3'd1;
            "t": verb_code_next = 3'd3;
            "e": verb_code_next = 3'd4;
            "w": verb_code_next = 3'd5;
            "r": verb_code_next = 3'd6;
            default: perr = brrv_pkg::EF_VERB;
          endcase
        end else begin
          logic [2:0] v;
          logic [2:0] vl;
          v = (field_char_count == 8'd1 && verb_code == 3'd0 && c == "i") ? 3'd2 : verb_code;
          verb_code_next = v;
          vl = (v == 3'd0 || v == 3'd1 || v == 3'd4) ? 3'd3 : 3'd4;
          if (field_char_count < {5'd0, vl}) begin
            if (verb_ch(v, field_char_count[1:0]) != c) perr = brrv_pkg::EF_VERB;
            else field_char_count_next = field_char_count + 8'd1;
          end else if (c == 8'h09) begin
            parse_phase_next = PH_DIG_ALGO; field_char_count_next = 8'd0;
          end else perr = brrv_pkg::EF_VERB;
        end
      end
      PH_DIG_ALGO: begin
        if (field_char_count == 8'd0) begin
          if (c == 8'h09) begin
            digest_empty_next = 1'b1; parse_phase_next = PH_CHAT; chat_pattern_next = 4'd0;
          end else if (!is_low(c)) perr = brrv_pkg::EF_DIGEST;
          else field_char_count_next = 8'd1;
        end else if (c == ":") begin
          parse_phase_next = PH_DIG_HASH; field_char_count_next = field_char_count + 8'd1;
        end else if ((is_low(c) || is_dig(c)) && field_char_count < 8'd8)
          field_char_count_next = field_char_count + 8'd1;
        else perr = brrv_pkg::EF_DIGEST;
      end
      PH_DIG_HASH: begin
        if (c == 8'h09) begin
          if (32'(field_char_count) < brrv_pkg::DigestMin) perr = brrv_pkg::EF_DIGEST;
          else begin
            parse_phase_next = PH_CHAT; chat_pattern_next = 4'd0; field_char_count_next = 8'd0;
          end
        end else if (!is_gr(c) || 32'(field_char_count) >= brrv_pkg::MaxDigestLen)
          perr = brrv_pkg::EF_DIGEST;
        else field_char_count_next = field_char_count + 8'd1;
      end
      PH_CHAT: begin
        if (c == 8'h09) begin
          if (!chat_ok) perr = brrv_pkg::EF_CHAT;
          else begin
            parse_phase_next = PH_COUNT; field_char_count_next = 8'd0;
          end
        end else begin
          logic [1:0] y;
          logic       sv;
          sv = 1'b1;
          case (c)
            "n": y = 2'd0;
            "o": y = 2'd1;
            "k": y = 2'd2;
            ",": y = 2'd3;
            default: begin y = 2'd0; sv = 1'b0; end
          endcase
          if (!sv) perr = brrv_pkg::EF_CHAT;
          else begin
            chat_pattern_next = chat_nx(chat_pattern, y);
            if (chat_pattern_next == 4'd15) perr = brrv_pkg::EF_CHAT;
          end
        end
      end
      PH_COUNT: begin
        if (is_dig(c) && field_char_count < 8'd20) begin
          if (count_accum > brrv_pkg::CountLimit || cmul > {4'd0, brrv_pkg::CountLimit})
            count_accum_next = brrv_pkg::CountLimit + 64'd1;
          else count_accum_next = cmul[63:0];
          field_char_count_next = field_char_count + 8'd1;
        end else if (c == 8'h09 && field_char_count >= 8'd1 &&
                     count_accum <= brrv_pkg::CountLimit) begin
          parse_phase_next = PH_SEC; field_char_count_next = 8'd0;
        end else perr = brrv_pkg::EF_COUNT;
      end
      PH_SEC: begin
        if (is_dig(c) && field_char_count < 8'd10) begin
          if (seconds_accum > brrv_pkg::SecondsLimit || smul > {4'd0, brrv_pkg::SecondsLimit})
            seconds_accum_next = brrv_pkg::SecondsLimit + 32'd1;
          else seconds_accum_next = smul[31:0];
          field_char_count_next = field_char_count + 8'd1;
        end else if (c == "." && field_char_count >= 8'd1 &&
                     seconds_accum <= brrv_pkg::SecondsLimit) begin
          parse_phase_next = PH_NS; field_char_count_next = 8'd0;
        end else perr = brrv_pkg::EF_DURATION;
      end
      PH_NS: begin
        if (is_dig(c) && field_char_count < 8'd9) field_char_count_next = field_char_count + 8'd1;
        else if (c == 8'h0a && field_char_count >= 8'd1) parse_phase_next = PH_DONE;
        else perr = brrv_pkg::EF_DURATION;
      end
      default: perr = brrv_pkg::EF_TIME;
    endcase
    line_char_count_next = line_char_count;
    if (32'(line_char_count) <= brrv_pkg::MaxLineLen) line_char_count_next = line_char_count + 9'd1;
    line_failed_next = line_failed;
    if (line_failed_next == 4'd0 && 32'(line_char_count_next) > brrv_pkg::MaxLineLen)
      line_failed_next = brrv_pkg::EF_LENGTH;
    if (line_failed_next == 4'd0) line_failed_next = perr;
  end

  logic [31:0] lc_inc;
  assign lc_inc = (line_counter == 32'hFFFF_FFFF) ? line_counter : line_counter + 32'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      parse_phase <= PH_TS; field_char_count <= '0; line_char_count <= '0;
      verb_code <= '0; chat_pattern <= '0; digest_empty <= 1'b0;
      count_accum <= '0; seconds_accum <= '0; line_failed <= '0;
      stream_bad <= 1'b0; seen_input <= 1'b0; line_counter <= '0;
    end else if (take && item.end_of_stream) begin
      res_valid <= 1'b1;
      res.status <= !seen_input ? brrv_pkg::ST_EMPTY :
                    (stream_bad || line_char_count != 9'd0) ? brrv_pkg::ST_STREAM_BAD :
                    brrv_pkg::ST_STREAM_OK;
      res.error_field <= brrv_pkg::EF_NONE;
      res.line_number <= (line_char_count != 9'd0) ? lc_inc : line_counter;
      parse_phase <= PH_TS; field_char_count <= '0; line_char_count <= '0;
      verb_code <= '0; chat_pattern <= '0; digest_empty <= 1'b0;
      count_accum <= '0; seconds_accum <= '0; line_failed <= '0;
      stream_bad <= 1'b0; seen_input <= 1'b0; line_counter <= '0;
    end else if (take && c == 8'h0a) begin
      res_valid <= 1'b1;
      seen_input <= 1'b1;
      res.status <= (line_failed_next != 4'd0) ? brrv_pkg::ST_LINE_BAD : brrv_pkg::ST_LINE_OK;
      res.error_field <= line_failed_next;
      res.line_number <= lc_inc;
      line_counter <= lc_inc;
      if (line_failed_next != 4'd0) stream_bad <= 1'b1;
      parse_phase <= PH_TS; field_char_count <= '0; line_char_count <= '0;
      verb_code <= '0; chat_pattern <= '0; digest_empty <= 1'b0;
      count_accum <= '0; seconds_accum <= '0; line_failed <= '0;
    end else if (take) begin
      res_valid <= 1'b0;
      seen_input <= 1'b1;
      if (line_failed == 4'd0) begin
        parse_phase <= parse_phase_next; field_char_count <= field_char_count_next;
        verb_code <= verb_code_next; chat_pattern <= chat_pattern_next;
        digest_empty <= digest_empty_next; count_accum <= count_accum_next;
        seconds_accum <= seconds_accum_next;
      end
      line_char_count <= line_char_count_next;
      line_failed <= line_failed_next;
    end else begin
      res_valid <= 1'b0;
    end
  end
endmodule

// ===== rtl/core/brrv_queue.sv =====
// Result queue between the parser and the output port.
// Depends on brrv_pkg.
module brrv_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  brrv_pkg::out_item_t wdata,
  input  logic                pop,
  output logic                nonempty,
  output logic                almost_full,
  output brrv_pkg::out_item_t rdata
);
  localparam int AW = $clog2(brrv_pkg::QDepth);
  brrv_pkg::out_item_t mem [brrv_pkg::QDepth];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   cnt;

  assign nonempty = cnt != '0;
  assign almost_full = 32'(cnt) >= brrv_pkg::QDepth - 1;
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

// ===== rtl/core/blob_request_record_validator_unit.sv =====
// Top level of the request record validator: parser front, result queue back.
// Depends on brrv_pkg, brrv_front, brrv_queue and the assertion header.
//
// Usage: bytes of a tab-separated request log arrive on the in channel
// (in_valid/in_stall/in_data), one byte per transaction. A newline yields
// one line verdict on the out channel; an end_of_stream transaction yields
// the stream verdict and returns the parser to its reset state.
// Throughput: one byte per cycle while in_stall is low.
// Path: a verdict passes one parse register, then one queue write, before
// it can be taken on the out channel.
// A four-entry queue holds verdicts; in_stall rises while the queue could
// not take a verdict from the byte in flight, so a stalled receiver loses
// nothing.
// Reset (rst, synchronous) clears the parser, counters and queue.
`include "blob_request_record_validator_unit_assert.svh"
module blob_request_record_validator_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  brrv_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output brrv_pkg::out_item_t out_data
);
  logic take, res_valid, nonempty, almost_full, pop;
  brrv_pkg::out_item_t res;

  assign in_stall = almost_full;
  assign take = in_valid && !in_stall;
  assign out_valid = nonempty;
  assign pop = nonempty && !out_stall;

  brrv_front u_front (.clk, .rst, .take, .item(in_data), .res_valid, .res);
  brrv_queue u_queue (.clk, .rst, .push(res_valid), .wdata(res), .pop, .nonempty,
                      .almost_full, .rdata(out_data));

  `BRRV_ASSERT_NXT(a_eos_result, clk, rst, take && in_data.end_of_stream, res_valid)
  `BRRV_ASSERT_NXT(a_no_overflow, clk, rst, in_stall, !res_valid)
  `BRRV_ASSERT_IMP(a_status_range, clk, rst, out_valid, out_data.status <= 3'd4)
endmodule
